@@ rtl/ccx_pkg.sv @@
// Shared types, constants and round functions for the ChaCha20 keystream XOR unit.
package ccx_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	localparam logic [6:0] MAX_BYTES = 7'd64;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_1 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_2 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_3 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HIGH = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_IETF = 3'd6;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [63:0] block_counter;
		logic [63:0] data_word_0;
		logic [63:0] data_word_1;
		logic [63:0] data_word_2;
		logic [63:0] data_word_3;
		logic [63:0] data_word_4;
		logic [63:0] data_word_5;
		logic [63:0] data_word_6;
		logic [63:0] data_word_7;
		logic [6:0]  valid_bytes;
		logic        keystream_only;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_word_0;
		logic [63:0] out_word_1;
		logic [63:0] out_word_2;
		logic [63:0] out_word_3;
		logic [63:0] out_word_4;
		logic [63:0] out_word_5;
		logic [63:0] out_word_6;
		logic [63:0] out_word_7;
		logic [6:0]  out_valid_bytes;
	} out_item_t;

	typedef struct packed {
		state_t           x;
		logic [63:0]      counter;
		logic [7:0][63:0] data;
		logic [6:0]       nbytes;
	} stage_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
		logic             ietf;
	} cfg_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic state_t init_state(cfg_t cfg, logic [63:0] counter);
		state_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			s[4 + 2 * i] = cfg.key[i][31:0];
			s[5 + 2 * i] = cfg.key[i][63:32];
		end
		s[12] = counter[31:0];
		if (cfg.ietf) begin
			s[13] = cfg.nonce_low[31:0];
			s[14] = cfg.nonce_low[63:32];
			s[15] = cfg.nonce_high;
		end else begin
			s[13] = counter[63:32];
			s[14] = cfg.nonce_low[31:0];
			s[15] = cfg.nonce_low[63:32];
		end
		return s;
	endfunction

	// First half rotates by 16 and 12, second half by 8 and 7.
	function automatic quad_t qr_half(quad_t q, logic second);
		quad_t r;
		r = q;
		r.a = r.a + r.b;
		r.d = r.d ^ r.a;
		r.d = second ? {r.d[23:0], r.d[31:24]} : {r.d[15:0], r.d[31:16]};
		r.c = r.c + r.d;
		r.b = r.b ^ r.c;
		r.b = second ? {r.b[24:0], r.b[31:25]} : {r.b[19:0], r.b[31:20]};
		return r;
	endfunction

endpackage

@@ rtl/ccx_ifs.sv @@
// Valid/ready channel interfaces for input blocks and result blocks.
interface ccx_in_if;
	import ccx_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ccx_out_if;
	import ccx_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/ccx_cell.sv @@
// One pipeline cell: half of a column or diagonal round on all four quarter-round lanes.
module ccx_cell #(
	parameter bit DIAG = 1'b0,
	parameter bit SECOND = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  ccx_pkg::stage_t in_stage,
	output logic            out_valid,
	output ccx_pkg::stage_t out_stage
);
	import ccx_pkg::*;

	localparam int D = DIAG ? 1 : 0;

	logic       valid_q;
	stage_t     stage_q;
	stage_t     stage_next;
	quad_t      q_in;
	quad_t      q_out;
	logic [3:0] ia;
	logic [3:0] ib;
	logic [3:0] ic;
	logic [3:0] id;

	always_comb begin
		stage_next = in_stage;
		q_in = '0;
		q_out = '0;
		ia = '0;
		ib = '0;
		ic = '0;
		id = '0;
		for (int i = 0; i < 4; i++) begin
			ia = 4'(i);
			ib = 4'(4 + ((i + D) % 4));
			ic = 4'(8 + ((i + 2 * D) % 4));
			id = 4'(12 + ((i + 3 * D) % 4));
			q_in = '{a: in_stage.x[ia], b: in_stage.x[ib], c: in_stage.x[ic], d: in_stage.x[id]};
			q_out = qr_half(q_in, SECOND);
			stage_next.x[ia] = q_out.a;
			stage_next.x[ib] = q_out.b;
			stage_next.x[ic] = q_out.c;
			stage_next.x[id] = q_out.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= stage_next;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

@@ rtl/chacha20_keystream_xor_unit.sv @@
// Top level of the ChaCha20 keystream XOR unit: config registers, cell chain, output stage.
//
// Usage:
//   Write key, nonce and layout through cfg_we/cfg_index/cfg_wdata while no block is in flight.
//   Each item on in_ch is one 64-byte block with its block counter; the counter is
//   advanced by the sender. Each item on out_ch is the data XOR keystream (or the bare
//   keystream when keystream_only is set), with bytes past the valid count zeroed.
// Timing:
//   A chain of 4*DOUBLE_ROUNDS cells, each doing half a round on all four lanes, then the
//   feed-forward add, XOR and byte mask into the output register.
//   One block per cycle is sustained while out_ch takes results.
// Reset:
//   Clears the config registers to zero and empties the chain and output stage.
// Stall:
//   A result that out_ch does not take holds in the output register; one more lands in a
//   skid register, after which in_ch.ready drops and the whole chain holds until the skid
//   register drains. in_ch.ready depends on registered state only.
module chacha20_keystream_xor_unit #(
	parameter int DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ccx_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ccx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ccx_in_if.sink                           in_ch,
	ccx_out_if.source                        out_ch
);
	import ccx_pkg::*;

	localparam int NUM_CELLS = 4 * DOUBLE_ROUNDS;

	cfg_t                   cfg_q;
	logic                   en;
	stage_t                 entry;
	logic [6:0]             entry_n;
	stage_t                 cell_stage [NUM_CELLS];
	logic [NUM_CELLS-1:0]   cell_valid;
	stage_t                 last;
	logic                   last_valid;
	state_t                 s_fin;
	state_t                 ks;
	logic [7:0][63:0]       res_words;
	out_item_t              fin_item;
	logic                   out_valid_q;
	out_item_t              out_item_q;
	logic                   skid_valid_q;
	out_item_t              skid_item_q;
	logic                   arr;
	logic                   free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_0:      cfg_q.key[0] <= cfg_wdata;
				REG_KEY_1:      cfg_q.key[1] <= cfg_wdata;
				REG_KEY_2:      cfg_q.key[2] <= cfg_wdata;
				REG_KEY_3:      cfg_q.key[3] <= cfg_wdata;
				REG_NONCE_LOW:  cfg_q.nonce_low <= cfg_wdata;
				REG_NONCE_HIGH: cfg_q.nonce_high <= cfg_wdata[31:0];
				REG_IETF:       cfg_q.ietf <= cfg_wdata[0];
				default:        ;
			endcase
		end
	end

	assign en = !skid_valid_q;
	assign in_ch.ready = en;

	always_comb begin
		entry_n = (in_ch.payload.valid_bytes > MAX_BYTES) ? MAX_BYTES
		                                                   : in_ch.payload.valid_bytes;
		entry.x = init_state(cfg_q, in_ch.payload.block_counter);
		entry.counter = in_ch.payload.block_counter;
		entry.data[0] = in_ch.payload.data_word_0;
		entry.data[1] = in_ch.payload.data_word_1;
		entry.data[2] = in_ch.payload.data_word_2;
		entry.data[3] = in_ch.payload.data_word_3;
		entry.data[4] = in_ch.payload.data_word_4;
		entry.data[5] = in_ch.payload.data_word_5;
		entry.data[6] = in_ch.payload.data_word_6;
		entry.data[7] = in_ch.payload.data_word_7;
		if (in_ch.payload.keystream_only) begin
			entry.data = '0;
		end
		entry.nbytes = entry_n;
	end

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		if (k == 0) begin : g_first
			ccx_cell #(
				.DIAG(1'b0),
				.SECOND(1'b0)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (in_ch.valid),
				.in_stage (entry),
				.out_valid(cell_valid[k]),
				.out_stage(cell_stage[k])
			);
		end else begin : g_next
			ccx_cell #(
				.DIAG(((k / 2) % 2) == 1),
				.SECOND((k % 2) == 1)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (cell_valid[k-1]),
				.in_stage (cell_stage[k-1]),
				.out_valid(cell_valid[k]),
				.out_stage(cell_stage[k])
			);
		end
	end

	assign last = cell_stage[NUM_CELLS-1];
	assign last_valid = cell_valid[NUM_CELLS-1];

	always_comb begin
		s_fin = init_state(cfg_q, last.counter);
		for (int w = 0; w < 16; w++) begin
			ks[w] = last.x[w] + s_fin[w];
		end
		for (int j = 0; j < 8; j++) begin
			res_words[j] = last.data[j] ^ {ks[2 * j + 1], ks[2 * j]};
			for (int b = 0; b < 8; b++) begin
				if (!(7'(8 * j + b) < last.nbytes)) begin
					res_words[j][8 * b +: 8] = 8'h00;
				end
			end
		end
		fin_item = '{
			out_word_0:      res_words[0],
			out_word_1:      res_words[1],
			out_word_2:      res_words[2],
			out_word_3:      res_words[3],
			out_word_4:      res_words[4],
			out_word_5:      res_words[5],
			out_word_6:      res_words[6],
			out_word_7:      res_words[7],
			out_valid_bytes: last.nbytes
		};
	end

	assign arr = en && last_valid;
	assign free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= arr;
			end
		end else if (arr) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_item_q <= skid_valid_q ? skid_item_q : fin_item;
		end else if (arr) begin
			skid_item_q <= fin_item;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_item_q;

endmodule

@@ rtl/ccx_checker.sv @@
// Port-level assertions for the ChaCha20 keystream XOR unit, bound to its top level.
module ccx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input ccx_pkg::out_item_t out_item
);
	import ccx_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("result changed while stalled");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_valid_bytes <= MAX_BYTES)
		else $error("valid byte count not saturated");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.out_valid_bytes <= 7'd56) |-> out_item.out_word_7 == 64'd0)
		else $error("bytes past valid count not cleared");

endmodule

bind chacha20_keystream_xor_unit ccx_checker u_ccx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_item (out_ch.payload)
);
